>>> rtl/number_identifier_colon_lexer_defines.svh
// Assertion macros shared by the lexer RTL files.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef NUMBER_IDENTIFIER_COLON_LEXER_DEFINES_SVH
`define NUMBER_IDENTIFIER_COLON_LEXER_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define NICL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define NICL_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/nicl_pkg.sv
// Types, constants and helper functions of the lexer.
// Used by every lexer module; depends on nothing.
package nicl_pkg;

  localparam int unsigned POS_BITS = 16;
  localparam int unsigned OUT_POS_BITS = 16;
  localparam int unsigned MAX_TOKS = 3;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [OUT_POS_BITS-1:0] opos_t;

  localparam pos_t POS_MAX = {POS_BITS{1'b1}};

  typedef enum logic [2:0] {
    KIND_NUMBER  = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_COLON   = 3'd2,
    KIND_END     = 3'd3,
    KIND_INVALID = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_DOT   = 3'd1,
    MODE_INT   = 3'd2,
    MODE_FRAC  = 3'd3,
    MODE_BAD   = 3'd4,
    MODE_IDENT = 3'd5
  } mode_e;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    kind_e kind;
    opos_t start;
    opos_t stop;
  } tok_t;

  // One queue word: all tokens caused by one input word.
  typedef struct packed {
    logic [1:0]         cnt;
    tok_t [MAX_TOKS-1:0] tok;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  function automatic pos_t sat_inc(pos_t p);
    return (p == POS_MAX) ? p : pos_t'(p + 1'b1);
  endfunction

  function automatic opos_t to_out(pos_t p);
    logic [31:0] w;
    w = 32'(p);
    return w[OUT_POS_BITS-1:0];
  endfunction

  function automatic tok_t mk_tok(kind_e k, pos_t b, pos_t e);
    tok_t t;
    t.kind  = k;
    t.start = to_out(b);
    t.stop  = to_out(e);
    return t;
  endfunction

endpackage

>>> rtl/number_identifier_colon_lexer.sv
// Top level of the streaming number / identifier / colon lexer.
// Instantiates nicl_front, nicl_fifo and nicl_back; uses nicl_pkg.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------------------
//   in      | sink      | in_valid_i / in_stall_o   | ch_i, has_char_i, is_final_i
//   out     | source    | out_valid_o / out_stall_i | token_kind_o, start_pos_o,
//           |           |                           | stop_pos_o, run_last_o
//
// Flow: one source word per cycle is taken while in_stall_o is low; each word's
// tokens (zero to three) leave one per cycle from the output register while
// out_stall_i is low, so a word's tokens leave one after another. The rate is set by
// the single token output port; the scan state machine updates on each accepted word.
// Path: each token is written into the queue, then loaded into the output register.
// Reset: rst_ni clears the scan state, the queue pointers and the output
// valid; the block is ready on the first cycle after reset.
// Stalls: in_stall_o rises only while the two-word queue is full; an output
// stall holds the current token and lets the front run until the queue fills.
module number_identifier_colon_lexer import nicl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        has_char_i,
  input  logic        is_final_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic [15:0] start_pos_o,
  output logic [15:0] stop_pos_o,
  output logic        run_last_o
);

  push_t  push;
  logic   full, empty, pop;
  entry_t rd;

  // Front: classify each character and build one queue word of tokens.
  nicl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .has_char_i (has_char_i),
    .is_final_i (is_final_i),
    .full_i     (full),
    .push_o     (push)
  );

  // Queue: decouple the scan from output back-pressure.
  nicl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .rd_o    (rd)
  );

  // Back: serialize tokens, marking the last one of each source word.
  nicl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .rd_i         (rd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_kind_o (token_kind_o),
    .start_pos_o  (start_pos_o),
    .stop_pos_o   (stop_pos_o),
    .run_last_o   (run_last_o)
  );

endmodule

>>> rtl/nicl_front.sv
// Front end of the lexer: accepts source words, runs the scan state machine
// and packs every token of one word into a queue word. Uses nicl_pkg.
`include "number_identifier_colon_lexer_defines.svh"

module nicl_front import nicl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       has_char_i,
  input  logic       is_final_i,
  input  logic       full_i,
  output push_t      push_o
);

  mode_e mode_q, mode_d;
  pos_t  start_q, start_d;
  pos_t  char_q, char_d;

  logic  acc;
  logic  is_space, is_digit, is_dot, is_alpha, is_colon;
  logic  fresh;
  mode_e mode_t;
  pos_t  start_t, pos_t_v;
  logic [1:0]          n_d;
  tok_t [MAX_TOKS-1:0] tok_d;

  assign in_stall_o = full_i;
  assign acc        = in_valid_i & ~full_i;

  assign is_space = (ch_i == 8'd32) || ((ch_i >= 8'd9) && (ch_i <= 8'd13));
  assign is_digit = (ch_i >= 8'd48) && (ch_i <= 8'd57);
  assign is_dot   = (ch_i == CH_DOT);
  assign is_colon = (ch_i == CH_COLON);
  assign is_alpha = ((ch_i >= 8'd65) && (ch_i <= 8'd90)) ||
                    ((ch_i >= 8'd97) && (ch_i <= 8'd122));

  always_comb begin
    mode_t  = mode_q;
    start_t = start_q;
    pos_t_v = char_q;
    fresh   = 1'b0;
    n_d     = 2'd0;
    tok_d   = '0;

    if (has_char_i) begin
      // Close or extend the pending token.
      case (mode_q)
        MODE_DOT: begin
          if (is_digit) begin
            mode_t = MODE_FRAC;
          end else begin
            tok_d[n_d] = mk_tok(KIND_INVALID, start_q, sat_inc(start_q));
            n_d   = n_d + 2'd1;
            fresh = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_dot) begin
            mode_t = MODE_FRAC;
          end else if (!is_digit) begin
            tok_d[n_d] = mk_tok(KIND_NUMBER, start_q, char_q);
            n_d   = n_d + 2'd1;
            fresh = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_dot) begin
            mode_t = MODE_BAD;
          end else if (!is_digit) begin
            tok_d[n_d] = mk_tok(KIND_NUMBER, start_q, char_q);
            n_d   = n_d + 2'd1;
            fresh = 1'b1;
          end
        end
        MODE_BAD: begin
          if (!is_digit && !is_dot) begin
            tok_d[n_d] = mk_tok(KIND_INVALID, start_q, char_q);
            n_d   = n_d + 2'd1;
            fresh = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (!is_alpha) begin
            tok_d[n_d] = mk_tok(KIND_IDENT, start_q, char_q);
            n_d   = n_d + 2'd1;
            fresh = 1'b1;
          end
        end
        default: begin
          fresh = 1'b1;
        end
      endcase

      // Lex the character afresh.
      if (fresh) begin
        mode_t = MODE_IDLE;
        if (is_space) begin
          mode_t = MODE_IDLE;
        end else if (is_digit) begin
          start_t = char_q;
          mode_t  = MODE_INT;
        end else if (is_dot) begin
          start_t = char_q;
          mode_t  = MODE_DOT;
        end else if (is_alpha) begin
          start_t = char_q;
          mode_t  = MODE_IDENT;
        end else if (is_colon) begin
          tok_d[n_d] = mk_tok(KIND_COLON, char_q, sat_inc(char_q));
          n_d = n_d + 2'd1;
        end else begin
          tok_d[n_d] = mk_tok(KIND_INVALID, char_q, sat_inc(char_q));
          n_d = n_d + 2'd1;
        end
      end
      pos_t_v = sat_inc(char_q);
    end

    mode_d  = mode_t;
    start_d = start_t;
    char_d  = pos_t_v;

    if (is_final_i) begin
      // Flush the pending token, then End at the length.
      case (mode_t)
        MODE_DOT: begin
          tok_d[n_d] = mk_tok(KIND_INVALID, start_t, sat_inc(start_t));
          n_d = n_d + 2'd1;
        end
        MODE_INT, MODE_FRAC: begin
          tok_d[n_d] = mk_tok(KIND_NUMBER, start_t, pos_t_v);
          n_d = n_d + 2'd1;
        end
        MODE_BAD: begin
          tok_d[n_d] = mk_tok(KIND_INVALID, start_t, pos_t_v);
          n_d = n_d + 2'd1;
        end
        MODE_IDENT: begin
          tok_d[n_d] = mk_tok(KIND_IDENT, start_t, pos_t_v);
          n_d = n_d + 2'd1;
        end
        default: begin
        end
      endcase
      tok_d[n_d] = mk_tok(KIND_END, pos_t_v, pos_t_v);
      n_d     = n_d + 2'd1;
      mode_d  = MODE_IDLE;
      start_d = '0;
      char_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      start_q <= '0;
      char_q  <= '0;
    end else if (acc) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      char_q  <= char_d;
    end
  end

  assign push_o.push      = acc & (n_d != 2'd0);
  assign push_o.entry.cnt = n_d;
  assign push_o.entry.tok = tok_d;

  `NICL_ASSERT(a_pos_step, (acc && has_char_i && !is_final_i && (char_q != POS_MAX)) |=> (char_q == pos_t'($past(char_q) + 1'b1)), "position did not advance by one")
  `NICL_ASSERT(a_final_clr, (acc && is_final_i) |=> ((char_q == '0) && (mode_q == MODE_IDLE)), "state not cleared after final word")

endmodule

>>> rtl/nicl_fifo.sv
// Two-word queue between the lexer front and back ends.
// Holds one queue word per input word with tokens. Uses nicl_pkg.
`include "number_identifier_colon_lexer_defines.svh"

module nicl_fifo import nicl_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  output logic   full_o,
  output logic   empty_o,
  input  logic   pop_i,
  output entry_t rd_o
);

  entry_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i.push & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rd_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `NICL_NEVER(a_push_full, push_i.push && full_o, "push into a full queue")
  `NICL_NEVER(a_pop_empty, pop_i && empty_o, "pop from an empty queue")

endmodule

>>> rtl/nicl_back.sv
// Back end of the lexer: takes queue words and sends their tokens out one
// per cycle while out_stall_i is low, through a registered output stage. Uses nicl_pkg.
`include "number_identifier_colon_lexer_defines.svh"

module nicl_back import nicl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  entry_t      rd_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output opos_t       start_pos_o,
  output opos_t       stop_pos_o,
  output logic        run_last_o
);

  entry_t     cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  logic       last, out_acc, load;
  tok_t       tok;

  assign tok     = cur_q.tok[idx_q];
  assign last    = (idx_q == (cur_q.cnt - 2'd1));
  assign out_acc = cur_valid_q & ~out_stall_i;
  assign load    = ~empty_i & (~cur_valid_q | (out_acc & last));
  assign pop_o   = load;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= rd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (load) begin
      cur_valid_q <= 1'b1;
      idx_q       <= 2'd0;
    end else if (out_acc) begin
      if (last) begin
        cur_valid_q <= 1'b0;
        idx_q       <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  assign out_valid_o  = cur_valid_q;
  assign token_kind_o = 3'(tok.kind);
  assign start_pos_o  = tok.start;
  assign stop_pos_o   = tok.stop;
  assign run_last_o   = last;

  `NICL_ASSERT(a_idx_range, cur_valid_q |-> (idx_q < cur_q.cnt), "token index beyond word count")
  `NICL_ASSERT(a_cnt_nz, cur_valid_q |-> (cur_q.cnt != 2'd0), "empty queue word in output stage")

endmodule
